FILE: src/bpcr_pkg.sv
// ----------------------------------------------------------------------------
// bpcr_pkg
// types and fixed widths of the two-ball collision response pipeline
// ----------------------------------------------------------------------------
package bpcr_pkg;

   localparam int unsigned VelWidth  = 32;
   localparam int unsigned RadWidth  = 24;
   localparam int unsigned MassWidth = 16;
   localparam int unsigned EWidth    = 17;
   localparam logic [EWidth-1:0] EOne = 17'h10000;

   // kick quotient bits, one divider stage each
   localparam int unsigned QuotWidth = 35;
   // shifted dividend and divisor widths
   localparam int unsigned NumWidth  = 101;
   localparam int unsigned DenWidth  = 68;

   typedef struct packed {
      logic signed [VelWidth-1:0]  first_pos_x;
      logic signed [VelWidth-1:0]  first_pos_y;
      logic signed [VelWidth-1:0]  first_vel_x;
      logic signed [VelWidth-1:0]  first_vel_y;
      logic signed [VelWidth-1:0]  second_pos_x;
      logic signed [VelWidth-1:0]  second_pos_y;
      logic signed [VelWidth-1:0]  second_vel_x;
      logic signed [VelWidth-1:0]  second_vel_y;
      logic        [RadWidth-1:0]  first_radius;
      logic        [RadWidth-1:0]  second_radius;
      logic        [MassWidth-1:0] first_mass;
      logic        [MassWidth-1:0] second_mass;
   } req_type;

   typedef struct packed {
      logic                       collided;
      logic signed [VelWidth-1:0] new_first_vel_x;
      logic signed [VelWidth-1:0] new_first_vel_y;
      logic signed [VelWidth-1:0] new_second_vel_x;
      logic signed [VelWidth-1:0] new_second_vel_y;
      logic                       saturated;
   } rsp_type;

   // per-item data that rides along the whole pipeline
   typedef struct packed {
      logic                       hit;
      logic                       dx_neg;
      logic                       dx_zero;
      logic                       dy_neg;
      logic                       dy_zero;
      logic signed [VelWidth-1:0] v1x;
      logic signed [VelWidth-1:0] v1y;
      logic signed [VelWidth-1:0] v2x;
      logic signed [VelWidth-1:0] v2y;
   } side_type;

endpackage

FILE: src/ball_pair_collision_response.sv
// ----------------------------------------------------------------------------
// ball_pair_collision_response
// planar two-ball contact test and restitution velocity exchange
// ----------------------------------------------------------------------------
// Fully pipelined: one ball pair may enter every cycle unless rsp_stall holds the
// result register full, and each produces one result. The pipeline is made of
// four arithmetic stages, one dividend setup stage, the 35-stage restoring
// dividers that form the four velocity kicks (one quotient bit per stage) and the
// output register. When rsp_stall holds the result register full, the whole
// pipeline freezes and req_stall rises in the same cycle. The restitution
// register is written through the csr channel, which is always ready; write it
// only while no transaction is in flight.
// ----------------------------------------------------------------------------
module ball_pair_collision_response
   import bpcr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [EWidth-1:0]   csr_data
);

   localparam int unsigned QW = QuotWidth;

   logic en;
   logic [EWidth-1:0] restitution_ff;

   // stage 1
   logic               s1_vld_ff;
   logic signed [32:0] s1_dx_ff, s1_dy_ff, s1_dvx_ff, s1_dvy_ff;
   logic [32:0]        s1_ax_ff, s1_ay_ff;
   logic [24:0]        s1_rsum_ff;
   logic [15:0]        s1_m1_ff, s1_m2_ff;
   logic [17:0]        s1_gain_ff;
   side_type           s1_side_ff;
   logic signed [32:0] dx_in, dy_in;
   logic [16:0]        e_in;

   // stage 2
   logic               s2_vld_ff, s2_near_ff;
   logic [49:0]        s2_ax2_ff, s2_ay2_ff, s2_rs2_ff;
   logic signed [65:0] s2_pdx_ff, s2_pdy_ff;
   logic [33:0]        s2_wg2_ff, s2_wg1_ff;
   logic [16:0]        s2_msum_ff;
   logic [24:0]        s2_ax_ff, s2_ay_ff;
   side_type           s2_side_ff;

   // stage 3
   logic               s3_vld_ff;
   logic [50:0]        s3_d2_ff;
   logic [58:0]        s3_ndot_ff;
   logic [57:0]        s3_wa_ff [4];
   logic [16:0]        s3_msum_ff;
   side_type           s3_side_ff;
   logic [50:0]        d2_in;
   logic signed [66:0] dot_in;
   logic [58:0]        wa_in [4];
   side_type           s3_side_in;

   // stage 4
   logic               s4_vld_ff;
   logic [DenWidth-1:0] s4_den_ff;
   logic [59:0]        s4_ll_ff [4];
   logic [57:0]        s4_lh_ff [4];
   logic [58:0]        s4_hl_ff [4];
   logic [56:0]        s4_hh_ff [4];
   side_type           s4_side_ff;

   // divider stages
   logic                dvld_ff  [QW+1];
   logic [DenWidth-1:0] dden_ff  [QW+1];
   side_type            dside_ff [QW+1];
   logic [DenWidth-1:0] drem_ff  [QW+1][4];
   logic [QW-1:0]       dlo_ff   [QW+1][4];
   logic [QW-1:0]       dq_ff    [QW+1][4];

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= EOne;
      end else if (csr_valid) begin
         restitution_ff <= csr_data;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j <= QW; j++) begin
            dvld_ff[j] <= 1'b0;
         end
      end else if (en) begin
         s1_vld_ff    <= req_valid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         dvld_ff[0]   <= s4_vld_ff;
         for (int j = 1; j <= QW; j++) begin
            dvld_ff[j] <= dvld_ff[j-1];
         end
         rsp_valid_ff <= dvld_ff[QW];
      end
   end

   // stage 1: differences, magnitudes, gain
   always_comb begin
      dx_in = 33'(req_data.first_pos_x) - 33'(req_data.second_pos_x);
      dy_in = 33'(req_data.first_pos_y) - 33'(req_data.second_pos_y);
      e_in  = (restitution_ff > EOne) ? EOne : restitution_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff   <= dx_in;
         s1_dy_ff   <= dy_in;
         s1_dvx_ff  <= 33'(req_data.first_vel_x) - 33'(req_data.second_vel_x);
         s1_dvy_ff  <= 33'(req_data.first_vel_y) - 33'(req_data.second_vel_y);
         s1_ax_ff   <= dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
         s1_ay_ff   <= dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
         s1_rsum_ff <= 25'(req_data.first_radius) + 25'(req_data.second_radius);
         s1_m1_ff   <= (req_data.first_mass == '0) ? 16'd1 : req_data.first_mass;
         s1_m2_ff   <= (req_data.second_mass == '0) ? 16'd1 : req_data.second_mass;
         s1_gain_ff <= 18'(EOne) + 18'(e_in);
         s1_side_ff.hit     <= 1'b0;
         s1_side_ff.dx_neg  <= dx_in[32];
         s1_side_ff.dx_zero <= (dx_in == '0);
         s1_side_ff.dy_neg  <= dy_in[32];
         s1_side_ff.dy_zero <= (dy_in == '0);
         s1_side_ff.v1x     <= req_data.first_vel_x;
         s1_side_ff.v1y     <= req_data.first_vel_y;
         s1_side_ff.v2x     <= req_data.second_vel_x;
         s1_side_ff.v2y     <= req_data.second_vel_y;
      end
   end

   // stage 2: squares, dot terms, mass weights
   always_ff @(posedge clock) begin
      if (en) begin
         s2_near_ff <= (s1_ax_ff <= 33'(s1_rsum_ff)) && (s1_ay_ff <= 33'(s1_rsum_ff));
         s2_ax2_ff  <= 50'(s1_ax_ff[24:0]) * 50'(s1_ax_ff[24:0]);
         s2_ay2_ff  <= 50'(s1_ay_ff[24:0]) * 50'(s1_ay_ff[24:0]);
         s2_rs2_ff  <= 50'(s1_rsum_ff) * 50'(s1_rsum_ff);
         s2_pdx_ff  <= 66'(s1_dx_ff) * 66'(s1_dvx_ff);
         s2_pdy_ff  <= 66'(s1_dy_ff) * 66'(s1_dvy_ff);
         s2_wg2_ff  <= 34'(s1_m2_ff) * 34'(s1_gain_ff);
         s2_wg1_ff  <= 34'(s1_m1_ff) * 34'(s1_gain_ff);
         s2_msum_ff <= 17'(s1_m1_ff) + 17'(s1_m2_ff);
         s2_ax_ff   <= s1_ax_ff[24:0];
         s2_ay_ff   <= s1_ay_ff[24:0];
         s2_side_ff <= s1_side_ff;
      end
   end

   // stage 3: contact decision and weighted distances
   always_comb begin
      d2_in    = 51'(s2_ax2_ff) + 51'(s2_ay2_ff);
      dot_in   = 67'(s2_pdx_ff) + 67'(s2_pdy_ff);
      wa_in[0] = 59'(s2_wg2_ff[32:0]) * 59'(s2_ax_ff);
      wa_in[1] = 59'(s2_wg2_ff[32:0]) * 59'(s2_ay_ff);
      wa_in[2] = 59'(s2_wg1_ff[32:0]) * 59'(s2_ax_ff);
      wa_in[3] = 59'(s2_wg1_ff[32:0]) * 59'(s2_ay_ff);
      s3_side_in     = s2_side_ff;
      s3_side_in.hit = s2_near_ff && (d2_in <= 51'(s2_rs2_ff)) && dot_in[66];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_d2_ff   <= d2_in;
         s3_ndot_ff <= 59'(-dot_in);
         for (int k = 0; k < 4; k++) begin
            s3_wa_ff[k] <= wa_in[k][57:0];
         end
         s3_msum_ff <= s2_msum_ff;
         s3_side_ff <= s3_side_in;
      end
   end

   // stage 4: divisor and split products
   always_ff @(posedge clock) begin
      if (en) begin
         s4_den_ff <= DenWidth'(s3_d2_ff) * DenWidth'(s3_msum_ff);
         for (int k = 0; k < 4; k++) begin
            s4_ll_ff[k] <= 60'(s3_ndot_ff[29:0])  * 60'(s3_wa_ff[k][29:0]);
            s4_lh_ff[k] <= 58'(s3_ndot_ff[29:0])  * 58'(s3_wa_ff[k][57:30]);
            s4_hl_ff[k] <= 59'(s3_ndot_ff[58:30]) * 59'(s3_wa_ff[k][29:0]);
            s4_hh_ff[k] <= 57'(s3_ndot_ff[58:30]) * 57'(s3_wa_ff[k][57:30]);
         end
         s4_side_ff <= s3_side_ff;
      end
   end

   // divider stage 0: assemble dividend
   for (genvar k = 0; k < 4; k++) begin : g_load
      logic [116:0]         num_in;
      logic [NumWidth-1:0]  nsh_in;

      always_comb begin
         num_in = 117'(s4_ll_ff[k]) + (117'(s4_lh_ff[k]) << 30)
                + (117'(s4_hl_ff[k]) << 30) + (117'(s4_hh_ff[k]) << 60);
         nsh_in = num_in[116:16];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[0][k] <= DenWidth'(nsh_in[NumWidth-1:QW]);
            dlo_ff[0][k]  <= nsh_in[QW-1:0];
            dq_ff[0][k]   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dden_ff[0]  <= s4_den_ff;
         dside_ff[0] <= s4_side_ff;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar j = 1; j <= QW; j++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            dden_ff[j]  <= dden_ff[j-1];
            dside_ff[j] <= dside_ff[j-1];
         end
      end

      for (genvar k = 0; k < 4; k++) begin : g_lane
         logic [DenWidth:0] rem2_in;
         logic [DenWidth:0] diff_in;
         logic              ge_in;

         always_comb begin
            rem2_in = {drem_ff[j-1][k], dlo_ff[j-1][k][QW-1]};
            diff_in = rem2_in - {1'b0, dden_ff[j-1]};
            ge_in   = (rem2_in >= {1'b0, dden_ff[j-1]});
         end

         always_ff @(posedge clock) begin
            if (en) begin
               drem_ff[j][k] <= ge_in ? diff_in[DenWidth-1:0] : rem2_in[DenWidth-1:0];
               dlo_ff[j][k]  <= {dlo_ff[j-1][k][QW-2:0], 1'b0};
               dq_ff[j][k]   <= {dq_ff[j-1][k][QW-2:0], ge_in};
            end
         end
      end
   end

   function automatic logic signed [36:0] add_kick(
      input logic signed [31:0] v,
      input logic [QW-1:0]      k,
      input logic               neg,
      input logic               zero,
      input logic               toward
   );
      logic signed [36:0] vv;
      logic signed [36:0] kk;
      vv = 37'(v);
      kk = signed'(37'(k));
      if (zero) begin
         return vv;
      end else if ((!neg) == toward) begin
         return vv + kk;
      end else begin
         return vv - kk;
      end
   endfunction

   function automatic logic [32:0] clip32(input logic signed [36:0] s);
      if (s > 37'sd2147483647) begin
         return {1'b1, 32'h7fff_ffff};
      end else if (s < -37'sd2147483648) begin
         return {1'b1, 32'h8000_0000};
      end else begin
         return {1'b0, s[31:0]};
      end
   endfunction

   // output: apply kick signs and saturate
   always_comb begin
      side_type    sd;
      logic [32:0] c1x, c1y, c2x, c2y;
      sd  = dside_ff[QW];
      c1x = clip32(add_kick(sd.v1x, dq_ff[QW][0], sd.dx_neg, sd.dx_zero, 1'b1));
      c1y = clip32(add_kick(sd.v1y, dq_ff[QW][1], sd.dy_neg, sd.dy_zero, 1'b1));
      c2x = clip32(add_kick(sd.v2x, dq_ff[QW][2], sd.dx_neg, sd.dx_zero, 1'b0));
      c2y = clip32(add_kick(sd.v2y, dq_ff[QW][3], sd.dy_neg, sd.dy_zero, 1'b0));
      rsp_in.collided = sd.hit;
      if (sd.hit) begin
         rsp_in.new_first_vel_x  = c1x[31:0];
         rsp_in.new_first_vel_y  = c1y[31:0];
         rsp_in.new_second_vel_x = c2x[31:0];
         rsp_in.new_second_vel_y = c2y[31:0];
         rsp_in.saturated        = c1x[32] | c1y[32] | c2x[32] | c2y[32];
      end else begin
         rsp_in.new_first_vel_x  = sd.v1x;
         rsp_in.new_first_vel_y  = sd.v1y;
         rsp_in.new_second_vel_x = sd.v2x;
         rsp_in.new_second_vel_y = sd.v2y;
         rsp_in.saturated        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule
